// ----- src/s88_fcd_pkg.sv -----
// ----------------------------------------------------------------------------
// s88_fcd_pkg
// Shared constants and types for the feedback change detector.
// ----------------------------------------------------------------------------
package s88_fcd_pkg;

   localparam int MEMORY_BYTES = 64;
   localparam int SLOT_W       = $clog2(MEMORY_BYTES);
   localparam int FB_W         = 10;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] LINE_END = 8'h0D;
   localparam logic [7:0] LINE_TAG = 8'h69;

   // one module record ready to be compared against the store
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [7:0]        lo_byte;
      logic [7:0]        hi_byte;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- src/s88_fcd_front.sv -----
// ----------------------------------------------------------------------------
// s88_fcd_front
// Line parser: splits the byte stream into lines and records, queues one
// job per complete in-range module record.
// ----------------------------------------------------------------------------
module s88_fcd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   input  s88_fcd_pkg::queue_status_type q_status,
   output logic                         push_valid,
   output s88_fcd_pkg::job_type         push_job
);
   import s88_fcd_pkg::*;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_COUNT  = 3'd1;
   localparam logic [2:0] PH_MODULE = 3'd2;
   localparam logic [2:0] PH_HIGH   = 3'd3;
   localparam logic [2:0] PH_LOW    = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        left_ff, left_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              in_range_ff, in_range_in;
   logic [7:0]        high_ff, high_in;
   logic              accept;
   logic [7:0]        b_dec;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign b_dec     = req_rx_byte - 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      slot_in     = slot_ff;
      in_range_in = in_range_ff;
      high_in     = high_ff;
      if (accept) begin
         if (req_rx_byte == LINE_END) begin
            phase_in = PH_START;
         end else begin
            case (phase_ff)
               PH_START: begin
                  phase_in = (req_rx_byte == LINE_TAG) ? PH_COUNT : PH_SKIP;
               end
               PH_COUNT: begin
                  left_in  = req_rx_byte;
                  phase_in = (req_rx_byte == 8'd0) ? PH_SKIP : PH_MODULE;
               end
               PH_MODULE: begin
                  // record fits if 2(n-1)+1 < store size, i.e. n <= size/2
                  in_range_in = (req_rx_byte != 8'd0) &&
                                ({1'b0, req_rx_byte} <= 9'(MEMORY_BYTES / 2));
                  slot_in     = in_range_in ? SLOT_W'({b_dec[6:0], 1'b0}) : '0;
                  phase_in    = PH_HIGH;
               end
               PH_HIGH: begin
                  high_in  = req_rx_byte;
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  left_in  = left_ff - 8'd1;
                  phase_in = (left_in == 8'd0) ? PH_SKIP : PH_MODULE;
               end
               default: begin
                  phase_in = PH_SKIP;
               end
            endcase
         end
      end
   end

   assign push_valid       = accept && (req_rx_byte != LINE_END) &&
                             (phase_ff == PH_LOW) && in_range_ff;
   assign push_job.slot    = slot_ff;
   assign push_job.lo_byte = req_rx_byte;
   assign push_job.hi_byte = high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         left_ff     <= '0;
         slot_ff     <= '0;
         in_range_ff <= 1'b0;
         high_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         slot_ff     <= slot_in;
         in_range_ff <= in_range_in;
         high_ff     <= high_in;
      end
   end

endmodule

// ----- src/s88_fcd_queue.sv -----
// ----------------------------------------------------------------------------
// s88_fcd_queue
// Short job queue between parser and change scanner.
// ----------------------------------------------------------------------------
module s88_fcd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  s88_fcd_pkg::job_type          push_job,
   input  logic                          pop,
   output s88_fcd_pkg::job_type          head_job,
   output s88_fcd_pkg::queue_status_type q_status
);
   import s88_fcd_pkg::*;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff;
   logic                 do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
      end
   end

endmodule

// ----- src/s88_fcd_back.sv -----
// ----------------------------------------------------------------------------
// s88_fcd_back
// Change scanner: reads the two stored bytes of a record, writes the new
// ones and emits one beat per changed contact.
// ----------------------------------------------------------------------------
module s88_fcd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  s88_fcd_pkg::queue_status_type q_status,
   input  s88_fcd_pkg::job_type          head_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [s88_fcd_pkg::FB_W-1:0]  rsp_feedback_number,
   output logic                          rsp_contact_state,
   output logic                          rsp_last
);
   import s88_fcd_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDLO = 3'd1;
   localparam logic [2:0] ST_RDHI = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   function automatic logic [3:0] lowest_set(input logic [15:0] v);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (v[i]) idx = 4'(i);
      end
      return idx;
   endfunction

   logic [7:0]        mem [MEMORY_BYTES];
   logic              valid_ff [MEMORY_BYTES];
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        stored;

   logic [2:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [15:0]       diff_ff, diff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FB_W-1:0]   rsp_number_ff, rsp_number_in;
   logic              rsp_state_ff, rsp_state_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [3:0]        pin;
   logic [15:0]       rem;
   logic [15:0]       new_bits;
   logic [11:0]       num_wide;
   logic              load;

   assign stored   = rd_valid_ff ? rd_data_ff : 8'h00;
   assign rd_addr  = (state_ff == ST_RDLO) ? job_ff.slot : job_ff.slot + 1'b1;
   assign new_bits = {job_ff.hi_byte, job_ff.lo_byte};
   assign pin      = lowest_set(diff_ff);
   assign rem      = diff_ff & (diff_ff - 16'd1);
   // byte slot+1 pins continue from slot*8+8, so pin index adds straight on
   assign num_wide = 12'({job_ff.slot, 3'b000}) + 12'(pin) + 12'd1;
   assign load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      diff_in       = diff_ff;
      wr_en         = 1'b0;
      wr_addr       = job_ff.slot;
      wr_data       = job_ff.lo_byte;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_number_in = rsp_number_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               job_in   = head_job;
               state_in = ST_RDLO;
            end
         end
         ST_RDLO: begin
            state_in = ST_RDHI;
         end
         ST_RDHI: begin
            diff_in[7:0] = stored ^ job_ff.lo_byte;
            wr_en        = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            diff_in[15:8] = stored ^ job_ff.hi_byte;
            wr_en         = 1'b1;
            wr_addr       = job_ff.slot + 1'b1;
            wr_data       = job_ff.hi_byte;
            state_in      = (diff_in == 16'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = num_wide[FB_W-1:0];
               rsp_state_in  = new_bits[pin];
               rsp_last_in   = (rem == 16'd0);
               diff_in       = rem;
               if (rem == 16'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // untouched entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEMORY_BYTES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      diff_ff       <= diff_in;
      rsp_number_ff <= rsp_number_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_feedback_number = rsp_number_ff;
   assign rsp_contact_state   = rsp_state_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ----- src/s88_feedback_change_detector.sv -----
// ----------------------------------------------------------------------------
// s88_feedback_change_detector
// Feedback line parser with contact change detection.
// ----------------------------------------------------------------------------
// path: job queue, then scanner states RDLO, RDHI, CMP; EMIT registers each beat
// throughput: one byte per cycle while the 2-entry job queue has room; each
//   record passes IDLE, RDLO, RDHI and CMP in the scanner, plus one EMIT step
//   per changed contact (contact store with one read and one write port: two
//   reads, two writes per record)
// reset: synchronous; parser returns to line start, queue empties and the
//   contact store reads as all zeros at once (per-entry valid bits)
module s88_feedback_change_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [s88_fcd_pkg::FB_W-1:0]  rsp_feedback_number,
   output logic                          rsp_contact_state,
   output logic                          rsp_last
);
   import s88_fcd_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push_valid;
   logic             pop;

   s88_fcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   s88_fcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   s88_fcd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .head_job            (head_job),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_feedback_number (rsp_feedback_number),
      .rsp_contact_state   (rsp_contact_state),
      .rsp_last            (rsp_last)
   );

endmodule

// ----- sim/s88_feedback_change_detector_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// s88_feedback_change_detector_tb
// Streams feedback lines into the change detector and checks every change
// beat against a line parser and contact image kept inside the bench.
// ----------------------------------------------------------------------------
module s88_feedback_change_detector_tb;
   import s88_fcd_pkg::*;

   localparam int IDLE_LIMIT        = 3000;
   localparam int DRAIN_CYCLES      = 40;
   localparam int RECORD_BYTES_GOAL = 36;
   localparam logic [7:0] WRONG_TAG = 8'h78;

   typedef enum logic [2:0] {
      PH_LINE_START,
      PH_COUNT,
      PH_MODULE,
      PH_HIGH,
      PH_LOW,
      PH_SKIP
   } parse_phase_type;

   typedef struct {
      logic [FB_W-1:0] fb_num;
      logic            occupied;
      logic            last_beat;
   } contact_change_type;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [7:0]      req_rx_byte = 8'h00;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [FB_W-1:0] rsp_feedback_number;
   logic            rsp_contact_state;
   logic            rsp_last;

   // parser and contact image of the detector as predicted
   parse_phase_type parse_phase = PH_LINE_START;
   logic [7:0]      modules_left = 8'h00;
   logic [7:0]      record_slot = 8'h00;
   logic            slot_in_range = 1'b0;
   logic [7:0]      pending_hi = 8'h00;
   logic [7:0]      contact_image [MEMORY_BYTES];

   // generator's guess of the store, used to shape small changes
   logic [7:0]      gen_image [MEMORY_BYTES];

   contact_change_type byte_changes [$];
   contact_change_type expected_changes [$];
   logic [7:0]         pending_bytes [$];
   contact_change_type want;

   int              sender_idle_pct = 0;
   int              receiver_idle_pct = 0;
   int              record_bytes_queued = 0;
   int              error_count = 0;
   int              idle_cycles = 0;
   int              req_beats_taken = 0;
   int              req_beats_seen = 0;
   logic            any_beat;

   logic [7:0] directed_bytes [27] = '{
      // two records, trailing junk: all contacts of module 1 set, last module
      LINE_TAG, 8'd2, 8'd1, 8'hFF, 8'hFF, 8'd32, 8'hA5, 8'h5A, 8'h77, LINE_END,
      // module 0, module past the store, then a record cut off by line end
      LINE_TAG, 8'd3, 8'd0, 8'h11, 8'h22, 8'd33, 8'h12, 8'h34, 8'd1, 8'h00,
      LINE_END,
      // wrong line type, then zero count
      WRONG_TAG, LINE_END, LINE_TAG, 8'd0, 8'd5, LINE_END
   };

   s88_feedback_change_detector u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_feedback_number (rsp_feedback_number),
      .rsp_contact_state   (rsp_contact_state),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   task automatic compare_store_byte(input int idx, input logic [7:0] now);
      logic [7:0]         diff;
      contact_change_type chg;
      diff = contact_image[idx] ^ now;
      contact_image[idx] = now;
      for (int pin = 0; pin < 8; pin++) begin
         if (diff[pin]) begin
            chg.fb_num    = FB_W'(idx * 8 + pin + 1);
            chg.occupied  = now[pin];
            chg.last_beat = 1'b0;
            byte_changes.push_back(chg);
         end
      end
   endtask

   task automatic predict_byte(input logic [7:0] b);
      int slot;
      byte_changes.delete();
      if (b == LINE_END) begin
         parse_phase = PH_LINE_START;
      end else begin
         case (parse_phase)
            PH_LINE_START: parse_phase = (b == LINE_TAG) ? PH_COUNT : PH_SKIP;
            PH_COUNT: begin
               modules_left = b;
               parse_phase = (b == 8'd0) ? PH_SKIP : PH_MODULE;
            end
            PH_MODULE: begin
               slot = (int'(b) - 1) * 2;
               slot_in_range = (b != 8'd0) && (slot + 1 < MEMORY_BYTES);
               record_slot = slot_in_range ? 8'(slot) : 8'd0;
               parse_phase = PH_HIGH;
            end
            PH_HIGH: begin
               pending_hi = b;
               parse_phase = PH_LOW;
            end
            PH_LOW: begin
               // low byte of the store pair is scanned first
               if (slot_in_range) begin
                  compare_store_byte(int'(record_slot), b);
                  compare_store_byte(int'(record_slot) + 1, pending_hi);
               end
               modules_left = modules_left - 8'd1;
               parse_phase = (modules_left == 8'd0) ? PH_SKIP : PH_MODULE;
            end
            default: parse_phase = PH_SKIP;
         endcase
      end
      if (byte_changes.size() != 0)
         byte_changes[byte_changes.size() - 1].last_beat = 1'b1;
      foreach (byte_changes[i])
         expected_changes.push_back(byte_changes[i]);
   endtask

   function automatic logic [7:0] any_but_line_end();
      logic [7:0] b;
      b = 8'($urandom_range(0, 254));
      if (b >= LINE_END)
         b = b + 8'd1;
      return b;
   endfunction

   function automatic logic [7:0] pick_module();
      logic [7:0] m;
      if ($urandom_range(0, 99) < 85) begin
         // inside the store, skipping the value that would end the line
         m = 8'($urandom_range(1, 31));
         if (m >= LINE_END)
            m = m + 8'd1;
      end else if ($urandom_range(0, 1) == 0) begin
         m = 8'd0;
      end else begin
         m = 8'($urandom_range(33, 255));
      end
      return m;
   endfunction

   function automatic logic [7:0] pick_data(input int idx);
      logic [7:0] base;
      base = 8'h00;
      if (idx >= 0 && idx < MEMORY_BYTES)
         base = gen_image[idx];
      case ($urandom_range(0, 3))
         0:       return 8'($urandom);
         1:       return base;
         default: return base ^ (8'h01 << $urandom_range(0, 7));
      endcase
   endfunction

   task automatic queue_record(input logic [7:0] module_num);
      logic [7:0] hi;
      logic [7:0] lo;
      int         slot;
      slot = (int'(module_num) - 1) * 2;
      hi = pick_data(slot + 1);
      lo = pick_data(slot);
      pending_bytes.push_back(module_num);
      pending_bytes.push_back(hi);
      pending_bytes.push_back(lo);
      if (module_num != 8'd0 && slot + 1 < MEMORY_BYTES) begin
         gen_image[slot]     = lo;
         gen_image[slot + 1] = hi;
      end
      record_bytes_queued += 3;
   endtask

   task automatic queue_line();
      int kind;
      int count;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         count = $urandom_range(1, 4);
         pending_bytes.push_back(LINE_TAG);
         pending_bytes.push_back(8'(count));
         repeat (count) queue_record(pick_module());
         if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3)) pending_bytes.push_back(any_but_line_end());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom));
      end else begin
         // record broken off part way
         pending_bytes.push_back(LINE_TAG);
         pending_bytes.push_back(8'($urandom_range(1, 4)));
         pending_bytes.push_back(pick_module());
         repeat ($urandom_range(0, 2)) pending_bytes.push_back(any_but_line_end());
      end
      pending_bytes.push_back(LINE_END);
   endtask

   // driver: new beat or idle at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_beats_taken != req_beats_seen) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_beats_seen = req_beats_taken;
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // monitor: predict on request beats, check change beats, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         any_beat = 1'b0;
         if (req_valid && req_ready) begin
            predict_byte(req_rx_byte);
            req_beats_taken++;
            any_beat = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            any_beat = 1'b1;
            if (expected_changes.size() == 0) begin
               $display("%0t: change beat with none expected: fb %0d state %0b last %0b",
                        $time, rsp_feedback_number, rsp_contact_state, rsp_last);
               error_count++;
            end else begin
               want = expected_changes.pop_front();
               if (rsp_feedback_number !== want.fb_num) begin
                  $display("%0t: feedback_number expected %0d actual %0d",
                           $time, want.fb_num, rsp_feedback_number);
                  error_count++;
               end
               if (rsp_contact_state !== want.occupied) begin
                  $display("%0t: contact_state expected %0b actual %0b (fb %0d)",
                           $time, want.occupied, rsp_contact_state, want.fb_num);
                  error_count++;
               end
               if (rsp_last !== want.last_beat) begin
                  $display("%0t: last expected %0b actual %0b (fb %0d)",
                           $time, want.last_beat, rsp_last, want.fb_num);
                  error_count++;
               end
            end
         end
         idle_cycles = any_beat ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      foreach (contact_image[i]) begin
         contact_image[i] = 8'h00;
         gen_image[i]     = 8'h00;
      end
      foreach (directed_bytes[i])
         pending_bytes.push_back(directed_bytes[i]);
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 22;
               receiver_idle_pct = 70;
            end
            1: begin
               sender_idle_pct   = 70;
               receiver_idle_pct = 22;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         record_bytes_queued = 0;
         while (record_bytes_queued < RECORD_BYTES_GOAL)
            queue_line();
         @(negedge clock);
         while (reset || pending_bytes.size() != 0 || req_valid ||
                expected_changes.size() != 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
src/s88_fcd_pkg.sv
src/s88_fcd_front.sv
src/s88_fcd_queue.sv
src/s88_fcd_back.sv
src/s88_feedback_change_detector.sv
sim/s88_feedback_change_detector_tb.sv
